// File: sv/gpp_pkg.sv
// ----------------------------------------------------------------------------
// gpp_pkg
// Types and constants shared by the grid pressure projection block.
// ----------------------------------------------------------------------------
package gpp_pkg;

    localparam int unsigned DEF_GRID_ROWS = 64;
    localparam int unsigned DEF_GRID_COLS = 64;

    localparam logic [7:0]  SWEEP_COUNT_RST = 8'd30;
    localparam logic [14:0] GAIN_RST        = 15'd31130;
    localparam logic [6:0]  ROWS_RST        = 7'd64;
    localparam logic [6:0]  COLS_RST        = 7'd64;

    localparam logic [1:0] REG_SWEEP_COUNT = 2'd0;
    localparam logic [1:0] REG_GAIN        = 2'd1;
    localparam logic [1:0] REG_ROWS        = 2'd2;
    localparam logic [1:0] REG_COLS        = 2'd3;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_SOLVE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] u_in;
        logic signed [31:0] v_in;
        logic               fluid_in;
    } gpp_in_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] u_out;
        logic signed [31:0] v_out;
        logic               fluid_out;
        logic               saturated;
    } gpp_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_CELL,
        ST_FL,
        ST_FR,
        ST_FU,
        ST_FD,
        ST_VD,
        ST_URT,
        ST_PROD,
        ST_CORR,
        ST_WB0,
        ST_WB1,
        ST_NEXT,
        ST_DONE
    } gpp_state_t;

    // Q1.16 reciprocal of the fluid neighbor count
    function automatic logic [16:0] recip_q16(input logic [2:0] s);
        logic [16:0] r;
        begin
            unique case (s)
                3'd1:    r = 17'd65536;
                3'd2:    r = 17'd32768;
                3'd3:    r = 17'd21845;
                3'd4:    r = 17'd16384;
                default: r = 17'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// File: sv/grid_pressure_projection.sv
// ----------------------------------------------------------------------------
// grid_pressure_projection
// Gauss-Seidel pressure projection over staggered grid memories.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall/in_data; one result item per input
// leaves on out_valid/out_stall/out_data. A write cell item loads u, v and
// the fluid flag of one cell; a read item returns one cell; a solve item runs
// sweep_count sweeps over the interior cells and then answers.
// A read goes through the synchronous memory read.
// In a solve, each interior cell is a sequence of memory reads, the
// divergence multiply, the gain multiply and two write-back states; a cell
// with no fluid neighbor is skipped after its reads.
// One item is worked on at a time; the result sits in an output register,
// and a new item is taken only once that register is empty or being read.
// Reset clears the control state, the saturation flag and the registers to
// their defaults; the grid memories are undefined until written. When the
// receiver stalls, the result holds and new items wait. The user writes the
// configuration (cfg_we/cfg_index/cfg_data) only when idle; not enforced.
// ----------------------------------------------------------------------------
module grid_pressure_projection
#(
    parameter int unsigned GRID_ROWS = gpp_pkg::DEF_GRID_ROWS,
    parameter int unsigned GRID_COLS = gpp_pkg::DEF_GRID_COLS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  gpp_pkg::gpp_in_t in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output gpp_pkg::gpp_out_t out_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [14:0]      cfg_data
);
    import gpp_pkg::*;

    localparam int unsigned RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int unsigned CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int unsigned AW = RW + CW;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned ROW_STEP = 1 << CW;
    localparam int unsigned IW = (RW > 7 ? RW : 7) + 1;
    localparam int unsigned JW = (CW > 7 ? CW : 7) + 1;

    logic signed [31:0] u_mem [DEPTH];
    logic signed [31:0] v_mem [DEPTH];
    logic               f_mem [DEPTH];

    logic [7:0]  sweep_count_reg;
    logic [14:0] gain_reg;
    logic [6:0]  rows_reg, cols_reg;

    gpp_state_t state_reg, state_next;
    gpp_out_t   out_reg;
    logic       out_valid_reg;
    logic       sat_reg;

    logic [7:0]    sw_reg;
    logic [IW-1:0] i_reg;
    logic [JW-1:0] j_reg;
    logic [IW-1:0] rows_eff;
    logic [JW-1:0] cols_eff;

    logic fl_reg, fr_reg, fu_reg;
    logic signed [31:0] vc_reg, uc_reg, vd_reg;
    logic signed [33:0] d_reg;
    logic [2:0]         s_reg;
    logic signed [35:0] q_reg;
    logic signed [38:0] c_reg;
    logic               fd_reg;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic signed [31:0] rd_u, rd_v;
    logic            rd_f;
    logic [1:0]      rkind_reg;
    logic            rinside_reg;

    logic [AW-1:0] c0_addr;
    assign c0_addr = {i_reg[RW-1:0], j_reg[CW-1:0]};

    assign rows_eff = (IW'(rows_reg) > IW'(GRID_ROWS)) ? IW'(GRID_ROWS) : IW'(rows_reg);
    assign cols_eff = (JW'(cols_reg) > JW'(GRID_COLS)) ? JW'(GRID_COLS) : JW'(cols_reg);

    logic accept;
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    logic in_inside;
    assign in_inside = (32'(in_data.row) < GRID_ROWS) && (32'(in_data.col) < GRID_COLS);

    logic [AW-1:0] in_addr;
    assign in_addr = {RW'(in_data.row), CW'(in_data.col)};

    // saturation of a wide sum to 32 bits, with its overflow test
    function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
        if (x > 40'sd2147483647)       return 32'h7FFF_FFFF;
        else if (x < -40'sd2147483648) return 32'h8000_0000;
        else                           return x[31:0];
    endfunction
    function automatic logic ovf32(input logic signed [39:0] x);
        return (x > 40'sd2147483647) || (x < -40'sd2147483648);
    endfunction

    logic signed [39:0] sum_a, sum_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.action == ACT_READ) state_next = ST_READ;
                else if (accept && in_data.action == ACT_SOLVE)
                begin
                    if (sweep_count_reg == 8'd0 || rows_eff < IW'(3) || cols_eff < JW'(3))
                        state_next = ST_DONE;
                    else
                        state_next = ST_CELL;
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_CELL:  state_next = ST_FL;
            ST_FL:    state_next = ST_FR;
            ST_FR:    state_next = ST_FU;
            ST_FU:    state_next = ST_FD;
            ST_FD:    state_next = ST_VD;
            ST_VD:
            begin
                if (s_reg == 3'd0) state_next = ST_NEXT;
                else               state_next = ST_URT;
            end
            ST_URT:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_CORR;
            ST_CORR:  state_next = ST_WB0;
            ST_WB0:   state_next = ST_WB1;
            ST_WB1:   state_next = ST_NEXT;
            ST_NEXT:
            begin
                if (j_reg + JW'(2) < cols_eff)        state_next = ST_CELL;
                else if (i_reg + IW'(2) < rows_eff)   state_next = ST_CELL;
                else if (sw_reg + 8'd1 < sweep_count_reg) state_next = ST_CELL;
                else                                  state_next = ST_DONE;
            end
            ST_DONE:  state_next = out_free ? ST_IDLE : ST_DONE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // memory read address: cycle-by-cycle walk over the neighbors
    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = c0_addr;
        unique case (state_reg)
            ST_IDLE: rd_addr = in_addr;
            ST_CELL: rd_addr = c0_addr - AW'(1);
            ST_FL:   rd_addr = c0_addr + AW'(1);
            ST_FR:   rd_addr = c0_addr - AW'(ROW_STEP);
            ST_FU:   rd_addr = c0_addr + AW'(ROW_STEP);
            ST_FD:   rd_addr = c0_addr;
            ST_VD:   rd_addr = c0_addr + AW'(1);
            default: rd_addr = c0_addr;
        endcase
    end

    // read data is registered and appears in the cycle after its address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_u <= u_mem[rd_addr];
            rd_v <= v_mem[rd_addr];
            rd_f <= f_mem[rd_addr];
        end
    end

    assign sum_a = 40'(vc_reg) - 40'(c_reg);
    assign sum_b = 40'(vd_reg) + 40'(c_reg);

    logic signed [39:0] uc_new, urt_new;
    logic signed [31:0] urt_reg;
    assign uc_new  = 40'(uc_reg) - 40'(c_reg);
    assign urt_new = 40'(urt_reg) + 40'(c_reg);

    logic fr_hold;
    logic [AW-1:0] cell_dn, cell_rt;
    assign cell_dn = c0_addr + AW'(ROW_STEP);
    assign cell_rt = c0_addr + AW'(1);

    // memory writes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept && in_data.action == ACT_WRITE && in_inside)
        begin
            u_mem[in_addr] <= in_data.u_in;
            v_mem[in_addr] <= in_data.v_in;
            f_mem[in_addr] <= in_data.fluid_in;
        end
        else if (state_reg == ST_WB0)
        begin
            // c0: v and u of the cell itself
            if (fu_reg) v_mem[c0_addr] <= sat32(sum_a);
            if (fl_reg) u_mem[c0_addr] <= sat32(uc_new);
        end
        else if (state_reg == ST_WB1)
        begin
            if (fd_reg) v_mem[cell_dn] <= sat32(sum_b);
            if (fr_hold) u_mem[cell_rt] <= sat32(urt_new);
        end
    end
    assign fr_hold = fr_reg;

    // rounding: floor(x/2^k + 1/2) is an add of half then arithmetic shift
    logic signed [51:0] qp_full, qp_sh;
    logic signed [51:0] cp_full, cp_sh;
    assign qp_full = -(52'(d_reg) * $signed({1'b0, recip_q16(s_reg)}));
    assign qp_sh   = (qp_full + 52'sd32768) >>> 16;
    assign cp_full = 52'(q_reg) * $signed({1'b0, gain_reg});
    assign cp_sh   = (cp_full + 52'sd8192) >>> 14;

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_FL: fl_reg <= rd_f;
            ST_FR: fr_reg <= rd_f;
            ST_FU: fu_reg <= rd_f;
            ST_FD:
            begin
                fd_reg <= rd_f;
                s_reg  <= 3'(fl_reg) + 3'(fr_reg) + 3'(fu_reg) + 3'(rd_f);
                vd_reg <= rd_v;
            end
            ST_VD:
            begin
                vc_reg <= rd_v;
                uc_reg <= rd_u;
            end
            ST_URT:
            begin
                urt_reg <= rd_u;
                d_reg   <= 34'(vd_reg) - 34'(vc_reg) + 34'(rd_u) - 34'(uc_reg);
            end
            ST_CORR: ;
            default: ;
        endcase
        if (state_reg == ST_PROD) q_reg <= 36'(qp_sh);
        if (state_reg == ST_CORR) c_reg <= 39'(cp_sh);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
            sat_reg         <= 1'b0;
            sweep_count_reg <= SWEEP_COUNT_RST;
            gain_reg        <= GAIN_RST;
            rows_reg        <= ROWS_RST;
            cols_reg        <= COLS_RST;
            sw_reg          <= '0;
            i_reg           <= IW'(1);
            j_reg           <= JW'(1);
            rkind_reg       <= ACT_WRITE;
            rinside_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SWEEP_COUNT: sweep_count_reg <= cfg_data[7:0];
                    REG_GAIN:        gain_reg        <= cfg_data;
                    REG_ROWS:        rows_reg        <= cfg_data[6:0];
                    REG_COLS:        cols_reg        <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;

            if (state_reg == ST_IDLE && accept)
            begin
                rkind_reg   <= in_data.action;
                rinside_reg <= in_inside;
                if (in_data.action == ACT_SOLVE)
                begin
                    sat_reg <= 1'b0;
                    sw_reg  <= '0;
                    i_reg   <= IW'(1);
                    j_reg   <= JW'(1);
                end
                else if (in_data.action != ACT_READ)
                begin
                    out_valid_reg <= 1'b1;
                    out_reg.kind      <= in_data.action;
                    out_reg.u_out     <= '0;
                    out_reg.v_out     <= '0;
                    out_reg.fluid_out <= 1'b0;
                    out_reg.saturated <= sat_reg;
                end
            end
            if (state_reg == ST_READ)
            begin
                out_valid_reg     <= 1'b1;
                out_reg.kind      <= rkind_reg;
                out_reg.u_out     <= rinside_reg ? rd_u : '0;
                out_reg.v_out     <= rinside_reg ? rd_v : '0;
                out_reg.fluid_out <= rinside_reg ? rd_f : 1'b0;
                out_reg.saturated <= sat_reg;
            end
            if (state_reg == ST_WB0)
                if ((fu_reg && ovf32(sum_a)) || (fl_reg && ovf32(uc_new))) sat_reg <= 1'b1;
            if (state_reg == ST_WB1)
                if ((fd_reg && ovf32(sum_b)) || (fr_reg && ovf32(urt_new))) sat_reg <= 1'b1;
            if (state_reg == ST_NEXT)
            begin
                if (j_reg + JW'(2) < cols_eff) j_reg <= j_reg + JW'(1);
                else
                begin
                    j_reg <= JW'(1);
                    if (i_reg + IW'(2) < rows_eff) i_reg <= i_reg + IW'(1);
                    else
                    begin
                        i_reg  <= IW'(1);
                        sw_reg <= sw_reg + 8'd1;
                    end
                end
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg     <= 1'b1;
                out_reg.kind      <= ACT_SOLVE;
                out_reg.u_out     <= '0;
                out_reg.v_out     <= '0;
                out_reg.fluid_out <= 1'b0;
                out_reg.saturated <= sat_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: tb/sv/grid_pressure_projection_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pressure_projection_tb
// Self-checking bench: loads the grid region that the tests use, runs directed
// solves at the register extremes and a long random mix of writes, reads and
// solves, predicting every result item from its own copy of the grid and registers.
// ----------------------------------------------------------------------------
module grid_pressure_projection_tb;
    import gpp_pkg::*;

    localparam int          ROWS      = 64;
    localparam int          COLS      = 64;
    localparam int          CELLS     = ROWS * COLS;
    localparam int          IDLE_LIMIT = 400000;
    localparam logic [1:0]  ACT_NOP   = 2'd3;
    localparam int          BLOCK     = 10;
    localparam int          EDGE_W    = 3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    gpp_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    gpp_out_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    grid_pressure_projection #(.GRID_ROWS(ROWS), .GRID_COLS(COLS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow grid and registers
    logic signed [31:0] u_shadow [CELLS];
    logic signed [31:0] v_shadow [CELLS];
    logic               fl_shadow [CELLS];
    logic               sat_shadow;
    logic [7:0]         sweeps_r;
    logic [14:0]        gain_r;
    logic [6:0]         rows_r;
    logic [6:0]         cols_r;

    gpp_out_t pending_results [$];
    int       errors;
    int       idle_cycles;
    int       burst_left;
    int       stall_mode;
    int       stall_timer;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report(input string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // cells that reads and solves use: a block at the origin plus strips
    // along the top rows and the left columns
    function automatic bit in_region(input int r, input int c);
        return (r < BLOCK && c < BLOCK) || r < EDGE_W || c < EDGE_W;
    endfunction

    function automatic int pick_col(input int r);
        if (r < BLOCK)
            return int'($urandom_range(0, BLOCK - 1));
        return int'($urandom_range(0, EDGE_W - 1));
    endfunction

    function automatic longint rnd_shift(input longint x, input int k);
        longint half;
        half = longint'(1) << (k - 1);
        if (x >= 0)
            return (x + half) >>> k;
        return -(((-x) + half - 1) >>> k);
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                     input longint delta);
        longint r;
        r = longint'(a) + delta;
        if (r > 64'sh7FFF_FFFF)
        begin
            sat_shadow = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (r < -64'sh8000_0000)
        begin
            sat_shadow = 1'b1;
            return 32'sh8000_0000;
        end
        return r[31:0];
    endfunction

    task automatic project_grid();
        int     nr, nc, c0, up, dn, lf, rt, s;
        longint d, q, c, rcp;
        nr = (rows_r > ROWS) ? ROWS : int'(rows_r);
        nc = (cols_r > COLS) ? COLS : int'(cols_r);
        sat_shadow = 1'b0;
        for (int sw = 0; sw < sweeps_r; sw++)
            for (int i = 1; i + 1 < nr; i++)
                for (int j = 1; j + 1 < nc; j++)
                begin
                    c0 = i * COLS + j;
                    up = c0 - COLS;
                    dn = c0 + COLS;
                    lf = c0 - 1;
                    rt = c0 + 1;
                    s = fl_shadow[dn] + fl_shadow[up] + fl_shadow[rt] + fl_shadow[lf];
                    if (s == 0)
                        continue;
                    case (s)
                        1: rcp = 65536;
                        2: rcp = 32768;
                        3: rcp = 21845;
                        default: rcp = 16384;
                    endcase
                    d = longint'(v_shadow[dn]) - longint'(v_shadow[c0])
                        + longint'(u_shadow[rt]) - longint'(u_shadow[c0]);
                    q = rnd_shift(-d * rcp, 16);
                    c = rnd_shift(q * longint'(gain_r), 14);
                    if (fl_shadow[up]) v_shadow[c0] = clamp_add(v_shadow[c0], -c);
                    if (fl_shadow[dn]) v_shadow[dn] = clamp_add(v_shadow[dn], c);
                    if (fl_shadow[lf]) u_shadow[c0] = clamp_add(u_shadow[c0], -c);
                    if (fl_shadow[rt]) u_shadow[rt] = clamp_add(u_shadow[rt], c);
                end
    endtask

    task automatic predict_item(input gpp_in_t it);
        gpp_out_t e;
        int       cell_idx;
        cell_idx = int'(it.row) * COLS + int'(it.col);
        e = '0;
        e.kind = it.action;
        case (it.action)
            ACT_WRITE:
            begin
                u_shadow[cell_idx]  = it.u_in;
                v_shadow[cell_idx]  = it.v_in;
                fl_shadow[cell_idx] = it.fluid_in;
            end
            ACT_SOLVE: project_grid();
            ACT_READ:
            begin
                e.u_out     = u_shadow[cell_idx];
                e.v_out     = v_shadow[cell_idx];
                e.fluid_out = fl_shadow[cell_idx];
            end
            default: ;
        endcase
        e.saturated = sat_shadow;
        pending_results.push_back(e);
    endtask

    // bursts of items with random gaps in between
    task automatic send_item(input gpp_in_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predict_item(it);
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SWEEP_COUNT: sweeps_r = val[7:0];
            REG_GAIN:        gain_r   = val;
            REG_ROWS:        rows_r   = val[6:0];
            default:         cols_r   = val[6:0];
        endcase
    endtask

    task automatic set_solve(input int sw, input int g, input int nr, input int nc);
        write_reg(REG_SWEEP_COUNT, 15'(sw));
        write_reg(REG_GAIN, 15'(g));
        write_reg(REG_ROWS, 15'(nr));
        write_reg(REG_COLS, 15'(nc));
    endtask

    function automatic logic signed [31:0] rand_vel();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return 32'($signed($urandom_range(0, 1 << 29)) - (1 << 28));
            default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        endcase
    endfunction

    task automatic put_cell(input int r, input int c, input logic signed [31:0] u,
                            input logic signed [31:0] v, input logic f);
        gpp_in_t it;
        it.action = ACT_WRITE;
        it.row = 6'(r);
        it.col = 6'(c);
        it.u_in = u;
        it.v_in = v;
        it.fluid_in = f;
        send_item(it);
    endtask

    task automatic simple_item(input logic [1:0] act, input int r, input int c);
        gpp_in_t it;
        it.action = act;
        it.row = 6'(r);
        it.col = 6'(c);
        it.u_in = $urandom;
        it.v_in = $urandom;
        it.fluid_in = $urandom_range(0, 1);
        send_item(it);
    endtask

    // the cells that solves and reads use are all written first
    task automatic test_fill_grid();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < COLS; c++)
                if (in_region(r, c))
                    put_cell(r, c, rand_vel(), rand_vel(), $urandom_range(0, 9) < 7);
    endtask

    task automatic test_default_regs();
        // default sweeps and gain, small region
        write_reg(REG_ROWS, 15'd5);
        write_reg(REG_COLS, 15'd5);
        simple_item(ACT_SOLVE, 0, 0);
        for (int k = 0; k < 5; k++)
            simple_item(ACT_READ, k, k);
    endtask

    task automatic test_directed();
        set_solve(1, 32767, 3, 3);
        put_cell(0, 1, 0, 0, 1);
        put_cell(2, 1, 0, 32'sh7FFF_FFFF, 1);
        put_cell(1, 0, 0, 0, 1);
        put_cell(1, 2, 32'sh7FFF_FFFF, 0, 1);
        put_cell(1, 1, 32'sh8000_0000, 32'sh8000_0000, 1);
        simple_item(ACT_SOLVE, 0, 0);
        simple_item(ACT_READ, 1, 1);
        simple_item(ACT_READ, 2, 1);
        simple_item(ACT_READ, 1, 2);
        // all neighbors solid: the cell is skipped
        put_cell(0, 1, 100, 100, 0);
        put_cell(2, 1, 100, 100, 0);
        put_cell(1, 0, 100, 100, 0);
        put_cell(1, 2, 100, 100, 0);
        simple_item(ACT_SOLVE, 0, 0);
        simple_item(ACT_READ, 1, 1);
        simple_item(ACT_NOP, 63, 63);
        simple_item(ACT_READ, 63, 2);
        simple_item(ACT_READ, 0, 0);
        // zero sweeps, zero gain, regions with no interior
        set_solve(0, 0, 3, 3);
        simple_item(ACT_SOLVE, 0, 0);
        set_solve(3, 0, 6, 6);
        simple_item(ACT_SOLVE, 0, 0);
        for (int n = 0; n < 3; n++)
        begin
            set_solve(2, 16384, n, 10);
            simple_item(ACT_SOLVE, 0, 0);
            set_solve(2, 16384, 10, n);
            simple_item(ACT_SOLVE, 0, 0);
        end
        simple_item(ACT_READ, 1, 1);
    endtask

    task automatic test_large_solves();
        int r;
        // sizes past the memory clip to the grid size
        set_solve(1, 31130, 127, 3);
        simple_item(ACT_SOLVE, 0, 0);
        set_solve(1, 20000, 3, 127);
        simple_item(ACT_SOLVE, 0, 0);
        set_solve(1, 12345, 100, 3);
        simple_item(ACT_SOLVE, 0, 0);
        set_solve(255, 32767, 3, 3);
        simple_item(ACT_SOLVE, 0, 0);
        for (int k = 0; k < 8; k++)
        begin
            r = $urandom_range(0, 63);
            simple_item(ACT_READ, r, pick_col(r));
        end
    endtask

    task automatic test_random_mix();
        int pick, lim, r;
        lim = 8;
        for (int n = 0; n < 1100; n++)
        begin
            if (n % 120 == 0)
            begin
                lim = $urandom_range(3, 9);
                set_solve($urandom_range(0, 4), $urandom_range(0, 1) ? $urandom_range(0, 32767)
                          : $urandom_range(14000, 32767), lim, $urandom_range(3, 9));
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if (pick < 38)
                    put_cell($urandom_range(0, lim), $urandom_range(0, 9), rand_vel(),
                             rand_vel(), $urandom_range(0, 9) < 7);
                else
                    put_cell($urandom_range(0, 63), $urandom_range(0, 63), rand_vel(),
                             rand_vel(), $urandom_range(0, 1));
            end
            else if (pick < 85)
            begin
                r = $urandom_range(0, 1) ? $urandom_range(0, 9) : $urandom_range(0, 63);
                simple_item(ACT_READ, r, pick_col(r));
            end
            else if (pick < 95)
                simple_item(ACT_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63));
            else
                simple_item(ACT_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
        end
    endtask

    // receiver: stall pattern and result checking
    always @(posedge clk)
    begin
        if (stall_timer == 0)
        begin
            stall_mode  <= $urandom_range(0, 3);
            stall_timer <= $urandom_range(20, 200);
        end
        else
            stall_timer <= stall_timer - 1;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= $urandom_range(0, 1);
        endcase

        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report("result item with none expected");
            else
            begin
                gpp_out_t e;
                e = pending_results.pop_front();
                if (out_data.kind !== e.kind)
                    report($sformatf("kind %0d want %0d", out_data.kind, e.kind));
                if (out_data.u_out !== e.u_out)
                    report($sformatf("u_out %h want %h", out_data.u_out, e.u_out));
                if (out_data.v_out !== e.v_out)
                    report($sformatf("v_out %h want %h", out_data.v_out, e.v_out));
                if (out_data.fluid_out !== e.fluid_out)
                    report($sformatf("fluid_out %b want %b", out_data.fluid_out,
                                     e.fluid_out));
                if (out_data.saturated !== e.saturated)
                    report($sformatf("saturated %b want %b", out_data.saturated,
                                     e.saturated));
            end
        end
    end

    // watchdog on cycles without any accepted item, delivered result or register write
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("grid_pressure_projection_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        burst_left  = 0;
        stall_mode  = 0;
        stall_timer = 0;
        sat_shadow  = 1'b0;
        sweeps_r    = SWEEP_COUNT_RST;
        gain_r      = GAIN_RST;
        rows_r      = ROWS_RST;
        cols_r      = COLS_RST;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_grid();
        test_default_regs();
        test_directed();
        test_large_solves();
        test_random_mix();

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("grid_pressure_projection_tb OK");
        else
            $display("grid_pressure_projection_tb NOT OK");
        $finish;
    end

endmodule
